// File: hw/rtl/assert_macros.svh
// Assertion macros shared by the lookup core modules; they expect clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define TTLU_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define TTLU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/ttlu_pkg.sv
// Shared types, constants and codes of the thermistor lookup core.
package ttlu_pkg;

  localparam int TABLE_DEPTH = 256;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int ENTRY_W     = 16;
  localparam int ADC_W       = 16;
  localparam int TEMP_W      = 16;
  localparam int STEP_W      = 7;
  localparam int COUNT_W     = IDX_W + 1;
  localparam int NUM_W       = ADC_W + STEP_W;
  localparam int DIV_CNT_W   = $clog2(NUM_W);
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;
  localparam int STATUS_W    = 2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_START = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COUNT = 2'd2;

  // Register reset values
  localparam logic [TEMP_W-1:0]  START_RST = 16'hFFF6;
  localparam logic [STEP_W-1:0]  STEP_RST  = 7'd1;
  localparam logic [COUNT_W-1:0] COUNT_RST = 9'd136;

  // Operations
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_CONV = 1'b1;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_OVER  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_UNDER = 2'd2;

  // Table read address select
  localparam logic [1:0] RSEL_R    = 2'd0;
  localparam logic [1:0] RSEL_ZERO = 2'd1;
  localparam logic [1:0] RSEL_MID  = 2'd2;
  localparam logic [1:0] RSEL_L    = 2'd3;

  typedef struct packed {
    logic               operation;
    logic [IDX_W-1:0]   entry_index;
    logic [ENTRY_W-1:0] entry_value;
    logic [ADC_W-1:0]   adc_reading;
  } in_word_t;

  typedef struct packed {
    logic signed [TEMP_W-1:0] temperature;
    logic [STATUS_W-1:0]      status;
  } out_word_t;

  // Controller to datapath
  typedef struct packed {
    logic       load_wr;
    logic       start;
    logic       rd_en;
    logic [1:0] rd_sel;
    logic       search_upd;
    logic       cap_vl;
    logic       cap_vr;
    logic       set_idx;
    logic       idx_use_r;
    logic       mark_over;
    logic       mark_under;
    logic       div_load;
    logic       div_step;
    logic       calc_res;
    logic       out_load;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic rd_gt;
    logic rd_eq;
    logic search_more;
    logic vd_zero;
    logic div_last;
    logic out_free;
  } sts_t;

endpackage

// File: hw/rtl/ttlu_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ttlu_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: hw/rtl/ttlu_ctrl.sv
// Sequencer for table lookup: range checks, binary search, divide and result handoff.
`include "assert_macros.svh"

module ttlu_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic           in_op,
  output logic           in_stall,
  input  ttlu_pkg::sts_t sts,
  output ttlu_pkg::cmd_t cmd
);

  import ttlu_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_RD_HI  = 4'd1;
  localparam logic [3:0] S_CHK_HI = 4'd2;
  localparam logic [3:0] S_CHK_LO = 4'd3;
  localparam logic [3:0] S_SRCH   = 4'd4;
  localparam logic [3:0] S_SCMP   = 4'd5;
  localparam logic [3:0] S_VL     = 4'd6;
  localparam logic [3:0] S_VR     = 4'd7;
  localparam logic [3:0] S_MUL    = 4'd8;
  localparam logic [3:0] S_DIV    = 4'd9;
  localparam logic [3:0] S_TEMP   = 4'd10;
  localparam logic [3:0] S_DONE   = 4'd11;

  logic [3:0] state_r;
  logic [3:0] state_nxt;
  logic       in_acc;

  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        cmd.load_wr = in_acc && (in_op == OP_LOAD);
        cmd.start   = in_acc && (in_op == OP_CONV);
        if (cmd.start) begin
          state_nxt = S_RD_HI;
        end
      end
      S_RD_HI: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RSEL_R;
        state_nxt  = S_CHK_HI;
      end
      S_CHK_HI: begin
        // word below the last entry: over range
        if (!sts.rd_gt && !sts.rd_eq) begin
          cmd.mark_over = 1'b1;
          state_nxt     = S_DONE;
        end else if (sts.rd_eq) begin
          cmd.set_idx   = 1'b1;
          cmd.idx_use_r = 1'b1;
          state_nxt     = S_TEMP;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RSEL_ZERO;
          state_nxt  = S_CHK_LO;
        end
      end
      S_CHK_LO: begin
        if (sts.rd_gt) begin
          cmd.mark_under = 1'b1;
          state_nxt      = S_DONE;
        end else if (sts.rd_eq) begin
          // left bound still sits at entry zero
          cmd.set_idx = 1'b1;
          state_nxt   = S_TEMP;
        end else begin
          state_nxt = S_SRCH;
        end
      end
      S_SRCH: begin
        cmd.rd_en = 1'b1;
        if (sts.search_more) begin
          cmd.rd_sel = RSEL_MID;
          state_nxt  = S_SCMP;
        end else begin
          cmd.rd_sel = RSEL_L;
          state_nxt  = S_VL;
        end
      end
      S_SCMP: begin
        cmd.search_upd = 1'b1;
        state_nxt      = S_SRCH;
      end
      S_VL: begin
        cmd.cap_vl = 1'b1;
        if (sts.rd_gt || sts.rd_eq) begin
          cmd.set_idx = 1'b1;
          state_nxt   = S_TEMP;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RSEL_R;
          state_nxt  = S_VR;
        end
      end
      S_VR: begin
        cmd.cap_vr    = 1'b1;
        cmd.set_idx   = 1'b1;
        cmd.idx_use_r = 1'b1;
        state_nxt     = sts.vd_zero ? S_TEMP : S_MUL;
      end
      S_MUL: begin
        cmd.div_load = 1'b1;
        state_nxt    = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = S_TEMP;
        end
      end
      S_TEMP: begin
        cmd.calc_res = 1'b1;
        state_nxt    = S_DONE;
      end
      S_DONE: begin
        // hold until the output register can take the word
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  `TTLU_ASSERT_NEXT(a_div_exit, state_r == S_DIV, state_r == S_DIV || state_r == S_TEMP, "divider sequence left early")
  `TTLU_ASSERT_NOW(a_search_exit, state_r == S_VL, !sts.search_more, "search ended with an open window")

endmodule

// File: hw/rtl/ttlu_dp.sv
// Datapath: configuration registers, curve table, search window, divider and output register.
`include "assert_macros.svh"

module ttlu_dp (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [ttlu_pkg::CFG_IDX_W-1:0]       cfg_idx,
  input  logic [ttlu_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  input  ttlu_pkg::in_word_t                   in_word,
  input  ttlu_pkg::cmd_t                       cmd,
  output ttlu_pkg::sts_t                       sts,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output ttlu_pkg::out_word_t                  out_word
);

  import ttlu_pkg::*;

  logic [TEMP_W-1:0]   start_r;
  logic [STEP_W-1:0]   step_r;
  logic [COUNT_W-1:0]  count_r;
  logic [ADC_W-1:0]    adc_r;
  logic [IDX_W-1:0]    l_r;
  logic [IDX_W-1:0]    r_r;
  logic [IDX_W-1:0]    idx_r;
  logic [ENTRY_W-1:0]  vl_r;
  logic [ENTRY_W-1:0]  vr_r;
  logic [ENTRY_W-1:0]  vd_r;
  logic [ENTRY_W-1:0]  rem_r;
  logic [NUM_W-1:0]    quo_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [STATUS_W-1:0] st_r;
  logic [TEMP_W-1:0]   res_r;
  logic                out_valid_r;
  out_word_t           out_word_r;

  logic [IDX_W-1:0]    last_idx;
  logic [IDX_W:0]      lr_sum;
  logic [IDX_W-1:0]    mid;
  logic [IDX_W-1:0]    raddr;
  logic [ENTRY_W-1:0]  rd_data;
  logic [NUM_W-1:0]    prod;
  logic [NUM_W-1:0]    num;
  logic [ENTRY_W:0]    rem_sh;
  logic                rem_ge;
  logic [TEMP_W-1:0]   idx_temp;

  // Clamp the entry count into 1..TABLE_DEPTH and take the last index
  always_comb begin
    priority if (count_r > COUNT_W'(TABLE_DEPTH)) begin
      last_idx = IDX_W'(TABLE_DEPTH - 1);
    end else if (count_r == '0) begin
      last_idx = '0;
    end else begin
      last_idx = IDX_W'(count_r - COUNT_W'(1));
    end
  end

  assign lr_sum = {1'b0, l_r} + {1'b0, r_r};
  assign mid    = lr_sum[IDX_W:1];

  always_comb begin
    unique case (cmd.rd_sel)
      RSEL_R:    raddr = r_r;
      RSEL_ZERO: raddr = '0;
      RSEL_MID:  raddr = mid;
      RSEL_L:    raddr = l_r;
      default:   raddr = r_r;
    endcase
  end

  ttlu_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (cmd.load_wr),
    .waddr (in_word.entry_index),
    .wdata (in_word.entry_value),
    .re    (cmd.rd_en),
    .raddr (raddr),
    .rdata (rd_data)
  );

  assign prod   = NUM_W'(step_r) * NUM_W'(adc_r - vr_r);
  assign num    = prod + NUM_W'(vd_r >> 1);
  assign rem_sh = {rem_r, quo_r[NUM_W-1]};
  assign rem_ge = rem_sh >= {1'b0, vd_r};

  assign idx_temp = TEMP_W'(idx_r) * TEMP_W'(step_r);

  assign sts.rd_gt       = adc_r > rd_data;
  assign sts.rd_eq       = adc_r == rd_data;
  assign sts.search_more = (r_r - l_r) > IDX_W'(1);
  assign sts.vd_zero     = vl_r == rd_data;
  assign sts.div_last    = cnt_r == DIV_CNT_W'(NUM_W - 1);
  assign sts.out_free    = !out_valid_r || !out_stall;

  // Configuration and control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r     <= START_RST;
      step_r      <= STEP_RST;
      count_r     <= COUNT_RST;
      l_r         <= '0;
      r_r         <= '0;
      st_r        <= ST_OK;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_idx)
          CFG_START: start_r <= cfg_wdata[TEMP_W-1:0];
          CFG_STEP:  step_r  <= cfg_wdata[STEP_W-1:0];
          CFG_COUNT: count_r <= cfg_wdata[COUNT_W-1:0];
          default:   ;
        endcase
      end
      if (cmd.start) begin
        l_r  <= '0;
        r_r  <= last_idx;
        st_r <= ST_OK;
      end else if (cmd.search_upd) begin
        // reading above the midpoint entry: answer lies left of it
        if (sts.rd_gt) begin
          r_r <= mid;
        end else begin
          l_r <= mid;
        end
      end
      if (cmd.mark_over) begin
        st_r <= ST_OVER;
      end else if (cmd.mark_under) begin
        st_r <= ST_UNDER;
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      adc_r <= in_word.adc_reading;
      quo_r <= '0;
    end else if (cmd.div_load) begin
      quo_r <= num;
      rem_r <= '0;
      cnt_r <= '0;
    end else if (cmd.div_step) begin
      rem_r <= rem_ge ? ENTRY_W'(rem_sh - {1'b0, vd_r}) : rem_sh[ENTRY_W-1:0];
      quo_r <= {quo_r[NUM_W-2:0], rem_ge};
      cnt_r <= cnt_r + DIV_CNT_W'(1);
    end
    if (cmd.cap_vl) begin
      vl_r <= rd_data;
    end
    if (cmd.cap_vr) begin
      vr_r <= rd_data;
      vd_r <= vl_r - rd_data;
    end
    if (cmd.set_idx) begin
      idx_r <= cmd.idx_use_r ? r_r : l_r;
    end
    if (cmd.calc_res) begin
      // quotient stays zero on paths without interpolation
      res_r <= start_r + idx_temp - quo_r[TEMP_W-1:0];
    end
    if (cmd.out_load) begin
      out_word_r.temperature <= (st_r == ST_OK) ? $signed(res_r) : '0;
      out_word_r.status      <= st_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  `TTLU_ASSERT_NOW(a_div_nonzero, cmd.div_step || cmd.div_load, vd_r != '0, "divide by a zero difference")
  `TTLU_ASSERT_NOW(a_window_order, 1'b1, l_r <= r_r, "search window bounds crossed")
  `TTLU_ASSERT_NOW(a_range_zero, out_valid_r && out_word_r.status != ST_OK, out_word_r.temperature == '0, "range error word carries a temperature")

endmodule

// File: hw/rtl/thermistor_table_temperature_lookup_core.sv
// Load item: the table entry is written at acceptance; no result word.
// Convert item: readings below the last entry, above entry zero or equal to either end give
// the result word without a search; others take a binary search on the table RAM's
// registered read port (at most 8 read-and-compare steps) and a restoring divider if needed.
// One convert item at a time; the next item is accepted the cycle after the result word is
// loaded. Synchronous reset: start -10, step 1, count 136; table undefined until loaded.
module thermistor_table_temperature_lookup_core (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  ttlu_pkg::in_word_t              in_word,
  output logic                            out_valid,
  input  logic                            out_stall,
  output ttlu_pkg::out_word_t             out_word,
  input  logic                            cfg_we,
  input  logic [ttlu_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [ttlu_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  import ttlu_pkg::*;

  cmd_t cmd;
  sts_t sts;

  ttlu_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_op    (in_word.operation),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  ttlu_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .in_word   (in_word),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

endmodule
